/* hw/rtl/sdel_pkg.sv */
`default_nettype none

package sdel_pkg;

    // Default depth of the held-character window (longest pattern).
    localparam int MAX_PATTERN_DEF = 8;

    // Payload widths fixed by the interface.
    localparam int CHAR_W    = 8;
    localparam int PAT_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

    // Depth of the queue between the front and the engine (power of two).
    localparam int QUEUE_DEPTH = 2;

    // One queued request: a text character and its end-of-text mark.
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              is_final;
    } sdel_item_t;

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_SCAN,
        ST_FLUSH
    } sdel_state_t;

endpackage

`default_nettype wire

/* hw/rtl/substring_delete_stream.sv */
// Channel     | Direction | Request contents
// ------------+-----------+--------------------------------------------------
// s_ (input)  | slave     | s_tdata[7:0] text_char; s_tlast is_final
// m_ (result) | master    | m_tdata[7:0] kept_char; m_tuser char_valid;
//             |           | m_tlast end_of_text
// cfg_        | write     | index 0 pattern_chars, index 1 pattern_length
//
// The engine takes each character into the held window, then checks the window
// against the pattern prefix and pushes out every character that can no longer
// start a match. A final request then flushes each held character, or gives a bare
// end marker if it released nothing at all. The engine's single sequencer handles
// one request at a time.
// Reset is synchronous and active low; it empties the queue, the held window
// and the output register, and restores the pattern to one zero character.
// Either side may stall freely: the queue and the output register decouple them.
`default_nettype none

module substring_delete_stream #(
    parameter int MAX_PATTERN = sdel_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sdel_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] text_char
    input  wire logic                            s_tlast,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sdel_pkg::CHAR_W-1:0]          m_tdata,   // [7:0] kept_char
    output logic                                 m_tuser,   // [0] char_valid
    output logic                                 m_tlast,

    input  wire logic                            cfg_wr_en,
    input  wire logic [sdel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sdel_pkg::PAT_W-1:0]      cfg_wdata
);

    logic [sdel_pkg::PAT_W-1:0] pattern_chars_reg;
    logic [sdel_pkg::LEN_W-1:0] pattern_length_reg;

    logic                 q_valid;
    sdel_pkg::sdel_item_t q_item;
    logic                 q_pop;

    // Configuration registers. The user must write only while the block is idle, so
    // the engine sees a settled pattern per request; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_chars_reg  <= '0;
            pattern_length_reg <= sdel_pkg::LEN_W'(1);
        end else if (cfg_wr_en) begin
            if (cfg_index == sdel_pkg::REG_PATTERN_CHARS) begin
                pattern_chars_reg <= cfg_wdata;
            end
            if (cfg_index == sdel_pkg::REG_PATTERN_LENGTH) begin
                pattern_length_reg <= cfg_wdata[sdel_pkg::LEN_W-1:0];
            end
        end
    end

    // The front takes requests in and queues them for the engine.
    sdel_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // The engine keeps the held window, drops whole matches and drives the
    // result register.
    sdel_engine #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_chars  (pattern_chars_reg),
        .cfg_length (pattern_length_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

/* hw/rtl/sdel_front.sv */
`default_nettype none

module sdel_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [sdel_pkg::CHAR_W-1:0] s_tdata,
    input  wire logic                      s_tlast,
    output logic                           q_valid,
    output sdel_pkg::sdel_item_t           q_item,
    input  wire logic                      q_pop
);

    localparam int QAW = (sdel_pkg::QUEUE_DEPTH > 1) ? $clog2(sdel_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(sdel_pkg::QUEUE_DEPTH + 1);

    sdel_pkg::sdel_item_t slot_reg [sdel_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] fill_reg, fill_next;
    logic           push;
    logic           pop;

    assign s_tready = (fill_reg != QCW'(sdel_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = slot_reg[rd_ptr_reg];

    assign push = s_tvalid && s_tready;
    assign pop  = q_pop && q_valid;

    // Pointers wrap naturally as the depth is a power of two.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + QCW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{text_char: s_tdata, is_final: s_tlast};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sdel_engine.sv */
`default_nettype none

module sdel_engine #(
    parameter int MAX_PATTERN = sdel_pkg::MAX_PATTERN_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic [sdel_pkg::PAT_W-1:0]   cfg_chars,
    input  wire logic [sdel_pkg::LEN_W-1:0]   cfg_length,
    input  wire logic                         q_valid,
    input  wire sdel_pkg::sdel_item_t         q_item,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [sdel_pkg::CHAR_W-1:0]       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    localparam int CW = $clog2(MAX_PATTERN + 1);

    sdel_pkg::sdel_state_t state_reg, state_next;

    logic [sdel_pkg::CHAR_W-1:0] hold_reg  [MAX_PATTERN];
    logic [sdel_pkg::CHAR_W-1:0] hold_next [MAX_PATTERN];
    logic [CW-1:0] count_reg, count_next;
    logic          fin_reg, fin_next;
    logic          emitted_reg, emitted_next;

    logic                        out_valid_reg;
    logic [sdel_pkg::CHAR_W-1:0] out_char_reg;
    logic                        out_cvalid_reg;
    logic                        out_end_reg;

    logic [CW-1:0]          eff_len;
    logic [CW-1:0]          rem_cnt;
    logic [MAX_PATTERN-1:0] match_cur;
    logic [MAX_PATTERN-1:0] match_nxt;
    logic                   cur_ok;
    logic                   cur_full;
    logic                   rem_full;
    logic                   out_free;

    logic                        emit;
    logic [sdel_pkg::CHAR_W-1:0] emit_char;
    logic                        emit_cvalid;
    logic                        emit_end;

    // Pattern characters beyond the eighth read as zero.
    function automatic logic [sdel_pkg::CHAR_W-1:0] pat_byte(
        input logic [sdel_pkg::PAT_W-1:0] chars,
        input int                         idx
    );
        logic [sdel_pkg::CHAR_W-1:0] b;
        b = '0;
        if (idx < sdel_pkg::PAT_W / sdel_pkg::CHAR_W) begin
            b = chars[idx*sdel_pkg::CHAR_W +: sdel_pkg::CHAR_W];
        end
        return b;
    endfunction

    always_comb begin
        if (cfg_length == '0) begin
            eff_len = CW'(1);
        end else if (32'(cfg_length) > MAX_PATTERN) begin
            eff_len = CW'(MAX_PATTERN);
        end else begin
            eff_len = CW'(cfg_length);
        end
    end

    // Per-position compares of the window as it stands and shifted by one.
    always_comb begin
        match_nxt = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            match_cur[i] = (hold_reg[i] == pat_byte(cfg_chars, i));
        end
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
            match_nxt[i] = (hold_reg[i+1] == pat_byte(cfg_chars, i));
        end
    end

    assign rem_cnt = count_reg - CW'(1);

    always_comb begin
        cur_ok   = (count_reg <= eff_len);
        rem_full = (count_reg != '0) && (rem_cnt == eff_len);
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CW'(i) < count_reg && !match_cur[i]) begin
                cur_ok = 1'b0;
            end
            if (CW'(i) < rem_cnt && !match_nxt[i]) begin
                rem_full = 1'b0;
            end
        end
        cur_full = cur_ok && (count_reg == eff_len);
    end

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        fin_next     = fin_reg;
        emitted_next = emitted_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        emit_char    = hold_reg[0];
        emit_cvalid  = 1'b1;
        emit_end     = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            hold_next[i] = hold_reg[i];
        end

        unique case (state_reg)
            sdel_pkg::ST_TAKE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    for (int i = 0; i < MAX_PATTERN; i++) begin
                        if (CW'(i) == count_reg) begin
                            hold_next[i] = q_item.text_char;
                        end
                    end
                    count_next   = count_reg + CW'(1);
                    fin_next     = q_item.is_final;
                    emitted_next = 1'b0;
                    state_next   = sdel_pkg::ST_SCAN;
                end
            end
            sdel_pkg::ST_SCAN: begin
                if (!cur_ok) begin
                    // Oldest character can no longer start a match.
                    if (out_free) begin
                        emit         = 1'b1;
                        emit_end     = fin_reg && ((count_reg == CW'(1)) || rem_full);
                        count_next   = rem_cnt;
                        emitted_next = 1'b1;
                        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                            hold_next[i] = hold_reg[i+1];
                        end
                    end
                end else begin
                    count_next = cur_full ? '0 : count_reg;
                    state_next = fin_reg ? sdel_pkg::ST_FLUSH : sdel_pkg::ST_TAKE;
                end
            end
            sdel_pkg::ST_FLUSH: begin
                if (count_reg == '0) begin
                    if (emitted_reg) begin
                        state_next = sdel_pkg::ST_TAKE;
                    end else if (out_free) begin
                        emit        = 1'b1;
                        emit_char   = '0;
                        emit_cvalid = 1'b0;
                        emit_end    = 1'b1;
                        state_next  = sdel_pkg::ST_TAKE;
                    end
                end else if (out_free) begin
                    emit         = 1'b1;
                    emit_end     = (count_reg == CW'(1));
                    count_next   = rem_cnt;
                    emitted_next = 1'b1;
                    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                        hold_next[i] = hold_reg[i+1];
                    end
                    if (count_reg == CW'(1)) begin
                        state_next = sdel_pkg::ST_TAKE;
                    end
                end
            end
            default: begin
                state_next = sdel_pkg::ST_TAKE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sdel_pkg::ST_TAKE;
            count_reg     <= '0;
            fin_reg       <= 1'b0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            emitted_reg <= emitted_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            hold_reg[i] <= hold_next[i];
        end
        if (emit) begin
            out_char_reg   <= emit_char;
            out_cvalid_reg <= emit_cvalid;
            out_end_reg    <= emit_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_cvalid_reg;
    assign m_tlast  = out_end_reg;

endmodule

`default_nettype wire

/* hw/rtl/sdel_checker.sv */
`default_nettype none

module sdel_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // A stalled result keeps its contents.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // A bare end marker only ever closes a text.
    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("bare marker without end of text");

    // A bare end marker carries a zero character.
    a_bare_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 8'd0)
        else $error("bare marker with non-zero data");

    // Nothing is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !$past(aresetn) |-> !m_tvalid)
        else $error("result offered straight after reset");

endmodule

bind substring_delete_stream sdel_checker u_sdel_checker (.*);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the streaming substring remover. Text characters go in on the s_
// channel, and the characters that survive come out on the m_ channel. A predictor inside the
// bench keeps its own held window and pattern registers. It works out what every accepted
// request should produce. The checker compares each result with the oldest prediction, one
// field at a time.
module tb;

    localparam int CHAR_W          = sdel_pkg::CHAR_W;
    localparam int PAT_W           = sdel_pkg::PAT_W;
    localparam int LEN_W           = sdel_pkg::LEN_W;
    localparam int CFG_IDX_W       = sdel_pkg::CFG_IDX_W;
    localparam int WIN_DEPTH       = sdel_pkg::MAX_PATTERN_DEF;
    localparam int QUIET_CYCLES    = 40;    // covers the queue, the engine and the output stage
    localparam int STALL_LIMIT     = 2000;  // cycles with no handshake or write, then give up
    localparam int HOLD_OFF_CYCLES = 90;    // the long receiver stall
    localparam int PRESSURE_AT     = 40;    // characters sent before that stall starts
    localparam int RAND_PHASES     = 10;
    localparam int FROM_PREDICTOR  = -1;    // directed row takes its results from the predictor

    // One result request as the checker sees it.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              valid;
        logic              eot;
    } kept_req_t;

    typedef enum logic {
        ROW_TEXT,
        ROW_REG
    } row_kind_t;

    // One line of the directed table. A text row can carry a typed-in result, and n_typed gives
    // how many results that is (0 or 1). FROM_PREDICTOR means the predictor's results are used.
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [PAT_W-1:0]      value;
        logic                  fin;
        int                    n_typed;
        kept_req_t             typed;
    } dir_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata   = '0;    // [7:0] text_char
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [CHAR_W-1:0]     m_tdata;           // [7:0] kept_char
    logic                  m_tuser;           // [0] char_valid
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [PAT_W-1:0]      cfg_wdata = '0;

    // This is the predictor's copy of the block's state and registers.
    logic [CHAR_W-1:0]     win_chars [0:WIN_DEPTH-1];
    int                    win_count   = 0;
    logic [PAT_W-1:0]      pat_bytes   = '0;
    logic [LEN_W-1:0]      pat_len_reg = LEN_W'(1);

    kept_req_t             kept_q[$];         // predicted results, oldest first
    dir_row_t              dir_rows[$];

    int  errors          = 0;
    int  results_checked = 0;
    int  chars_sent      = 0;
    int  texts_ended     = 0;
    int  matches_dropped = 0;
    int  regs_written    = 0;
    int  stall_cycles    = 0;
    bit  no_idle         = 1'b0;
    bit  calm            = 1'b0;

    // This is the alphabet of the current random phase. It is either the full byte range or
    // a few neighbouring codes, so that matches and near misses are common.
    bit  alph_wide       = 1'b1;
    int  alph_base       = 0;
    int  alph_size       = 2;

    substring_delete_stream u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // A length of zero behaves as one. A length above the window depth behaves as the full depth.
    function automatic int eff_len(input logic [LEN_W-1:0] n);
        if (n == 0)
            return 1;
        if (n > WIN_DEPTH)
            return WIN_DEPTH;
        return n;
    endfunction

    // This checks whether the held characters could still grow into the pattern.
    function automatic bit win_is_prefix(input int len);
        if (win_count > len)
            return 1'b0;
        for (int i = 0; i < win_count; i++) begin
            if (win_chars[i] != pat_bytes[8*i +: 8])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [CHAR_W-1:0] take_oldest();
        logic [CHAR_W-1:0] c;
        c = win_chars[0];
        for (int i = 1; i < win_count; i++)
            win_chars[i-1] = win_chars[i];
        win_count--;
        return c;
    endfunction

    // A new character joins the window. Each character at the front that can no longer start
    // a match is released. A window that equals the whole pattern is deleted. The last
    // character of a text flushes the window. If nothing at all is released, a bare end marker
    // is produced instead.
    function automatic void predict_deletion(input logic [CHAR_W-1:0] c, input logic fin);
        int len;
        int n0;
        bit settled;
        len = eff_len(pat_len_reg);
        n0 = kept_q.size();
        settled = 1'b0;
        win_chars[win_count] = c;
        win_count++;
        while (win_count > 0 && !settled) begin
            if (win_is_prefix(len)) begin
                settled = 1'b1;
                if (win_count == len) begin
                    win_count = 0;
                    matches_dropped++;
                end
            end else begin
                kept_q.push_back('{take_oldest(), 1'b1, 1'b0});
            end
        end
        if (fin) begin
            while (win_count > 0)
                kept_q.push_back('{take_oldest(), 1'b1, 1'b0});
            if (kept_q.size() == n0)
                kept_q.push_back('{'0, 1'b0, 1'b1});
            else
                kept_q[kept_q.size()-1].eot = 1'b1;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        if (alph_wide)
            return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'(alph_base + $urandom_range(0, alph_size - 1));
    endfunction

    function automatic void add_text(input logic [CHAR_W-1:0] c, input logic fin,
                                     input int n_typed, input kept_req_t typed);
        dir_row_t r;
        r.kind = ROW_TEXT;
        r.idx = '0;
        r.value = PAT_W'(c);
        r.fin = fin;
        r.n_typed = n_typed;
        r.typed = typed;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] v);
        dir_row_t r;
        r.kind = ROW_REG;
        r.idx = idx;
        r.value = v;
        r.fin = 1'b0;
        r.n_typed = 0;
        r.typed = '0;
        dir_rows.push_back(r);
    endfunction

    // The driving tasks below are all entered and left on a falling edge. This way, no signal
    // ever gets two assignments in one time step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == sdel_pkg::REG_PATTERN_CHARS)
            pat_bytes = value;
        else
            pat_len_reg = value[LEN_W-1:0];
        regs_written++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // This waits until every predicted result has come out. It then allows extra cycles for
    // requests that produce nothing but may still be working through the queue and the engine.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (kept_q.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    // This offers one text request and holds it until it is taken. The prediction is made at
    // the edge where the request is accepted.
    task automatic send_req(input logic [CHAR_W-1:0] c, input logic fin,
                            input int n_typed, input kept_req_t typed);
        int gap;
        int n0;
        if (!no_idle && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n0 = kept_q.size();
        predict_deletion(c, fin);
        if (n_typed != FROM_PREDICTOR) begin
            while (kept_q.size() > n0)
                void'(kept_q.pop_back());
            if (n_typed == 1)
                kept_q.push_back(typed);
        end
        chars_sent++;
        if (fin)
            texts_ended++;
        @(negedge aclk);
    endtask

    // The receiver stalls in random bursts. Once, after enough characters have been sent, it
    // holds off for a long stretch. The sender keeps offering during that stretch, so the
    // queue fills up and the block has to stop taking input.
    initial begin
        int  burst;
        int  hold;
        bit  pressed;
        burst = 0;
        hold = 0;
        pressed = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!pressed && chars_sent >= PRESSURE_AT && s_tvalid) begin
                pressed = 1'b1;
                hold = HOLD_OFF_CYCLES;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (burst > 0) begin
                m_tready <= 1'b0;
                burst--;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                burst = $urandom_range(1, 13) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // The checker compares every accepted result with the oldest prediction, field by field.
    always @(posedge aclk) begin
        kept_req_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (kept_q.size() == 0) begin
                errors++;
                $display("%0t: expected no result, actual kept_char %02h char_valid %0b eot %0b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = kept_q.pop_front();
                results_checked++;
                if (m_tdata !== want.ch) begin
                    errors++;
                    $display("%0t: kept_char expected %02h, actual %02h",
                             $time, want.ch, m_tdata);
                end
                if (m_tuser !== want.valid) begin
                    errors++;
                    $display("%0t: char_valid expected %0b, actual %0b",
                             $time, want.valid, m_tuser);
                end
                if (m_tlast !== want.eot) begin
                    errors++;
                    $display("%0t: end_of_text expected %0b, actual %0b",
                             $time, want.eot, m_tlast);
                end
            end
        end
    end

    // The watchdog counts cycles in which no request moves on either channel and no register
    // is written.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d results still expected",
                     $time, STALL_LIMIT, kept_q.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [PAT_W-1:0]  pat;
        logic [CHAR_W-1:0] text_q[$];
        kept_req_t         no_res;
        logic              fin;
        int                n;
        int                k;
        int                plen;
        int                plen_eff;
        int                piece;

        no_res = '0;

        // After reset the pattern is a single zero character. Anything else passes through,
        // and a lone zero is deleted, which leaves only a bare end marker.
        add_text(8'h01, 1'b1, 1, '{8'h01, 1'b1, 1'b1});
        add_text(8'h00, 1'b1, 1, '{8'h00, 1'b0, 1'b1});
        add_text(8'hFF, 1'b1, 1, '{8'hFF, 1'b1, 1'b1});
        // With a two-character pattern, a lone character passes, a repeated first character
        // releases one copy, and a full match vanishes.
        add_reg(sdel_pkg::REG_PATTERN_CHARS, 64'h4241);
        add_reg(sdel_pkg::REG_PATTERN_LENGTH, 64'd2);
        add_text("X", 1'b0, FROM_PREDICTOR, no_res);
        add_text("A", 1'b0, FROM_PREDICTOR, no_res);
        add_text("A", 1'b0, FROM_PREDICTOR, no_res);
        add_text("B", 1'b0, FROM_PREDICTOR, no_res);
        add_text("Y", 1'b1, FROM_PREDICTOR, no_res);
        // The pattern is changed while a character is still held. The held "A" is then checked
        // against the new pattern and released.
        add_text("A", 1'b0, FROM_PREDICTOR, no_res);
        add_reg(sdel_pkg::REG_PATTERN_CHARS, 64'h4443);
        add_text("D", 1'b1, FROM_PREDICTOR, no_res);
        // The longest pattern, broken at its last character, releases eight characters at once.
        add_reg(sdel_pkg::REG_PATTERN_CHARS, 64'h4847_4645_4443_4241);
        add_reg(sdel_pkg::REG_PATTERN_LENGTH, 64'd8);
        for (int i = 0; i < WIN_DEPTH - 1; i++)
            add_text(CHAR_W'("A" + i), 1'b0, FROM_PREDICTOR, no_res);
        add_text("X", 1'b1, FROM_PREDICTOR, no_res);
        // A length of zero behaves as one, so the top character is deleted by itself.
        add_reg(sdel_pkg::REG_PATTERN_CHARS, 64'hFFFF_FFFF_FFFF_FFFF);
        add_reg(sdel_pkg::REG_PATTERN_LENGTH, 64'd0);
        add_text(8'hFF, 1'b1, 1, '{8'h00, 1'b0, 1'b1});

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG) begin
                wait_quiet();
                write_reg(dir_rows[r].idx, dir_rows[r].value);
            end else begin
                send_req(dir_rows[r].value[CHAR_W-1:0], dir_rows[r].fin,
                         dir_rows[r].n_typed, dir_rows[r].typed);
            end
        end

        // Each random phase picks a new pattern and builds its text mostly from whole copies of
        // the pattern and from broken prefixes of it. A stray character or an early end of text
        // is mixed in now and then. A phase may stop partway through a text, so the next
        // pattern has to deal with what is still held.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_quiet();
            no_idle = (ph == RAND_PHASES - 1);
            calm = ($urandom_range(0, 2) == 0);
            k = $urandom_range(0, 9);
            if (k == 0)
                plen = 0;
            else if (k == 1)
                plen = $urandom_range(WIN_DEPTH + 1, 15);
            else
                plen = $urandom_range(1, WIN_DEPTH);
            plen_eff = eff_len(LEN_W'(plen));
            alph_wide = ($urandom_range(0, 3) == 0);
            alph_base = $urandom_range(0, 253);
            alph_size = $urandom_range(2, 3);
            pat = {$urandom, $urandom};
            for (int i = 0; i < plen_eff; i++)
                pat[8*i +: 8] = pick_char();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(sdel_pkg::REG_PATTERN_CHARS, pat);
                write_reg(sdel_pkg::REG_PATTERN_LENGTH, PAT_W'(plen));
            end else begin
                write_reg(sdel_pkg::REG_PATTERN_LENGTH, PAT_W'(plen));
                write_reg(sdel_pkg::REG_PATTERN_CHARS, pat);
            end

            n = $urandom_range(10, 22);
            text_q.delete();
            while (text_q.size() < n) begin
                piece = $urandom_range(0, 9);
                if (piece < 4) begin
                    for (int i = 0; i < plen_eff; i++)
                        text_q.push_back(pat[8*i +: 8]);
                end else if (piece < 6 && plen_eff > 1) begin
                    k = $urandom_range(1, plen_eff - 1);
                    for (int i = 0; i < k; i++)
                        text_q.push_back(pat[8*i +: 8]);
                end else begin
                    text_q.push_back(pick_char());
                end
            end
            while (text_q.size() > n)
                void'(text_q.pop_back());

            for (int i = 0; i < n; i++) begin
                if (i == n - 1)
                    fin = no_idle || ($urandom_range(0, 3) != 0);
                else
                    fin = ($urandom_range(0, 11) == 0);
                send_req(text_q[i], fin, FROM_PREDICTOR, no_res);
            end
        end

        wait_quiet();

        $display("Sent %0d characters ending %0d texts, with %0d register writes (lengths 0-15).",
                 chars_sent, texts_ended, regs_written);
        $display("Checked %0d results, and %0d pattern occurrences were deleted.",
                 results_checked, matches_dropped);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
